// File: src/pwes_pkg.sv
// ----------------------------------------------------------------------------
// pwes_pkg
// Shared types and constants of the position window event sorter.
// ----------------------------------------------------------------------------
package pwes_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int POSITION_BITS = 48;
    localparam int TRACK_BITS    = 8;
    localparam int PORT_IDX_W    = 4;
    localparam int TAB_AW        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 3);

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_POLL  = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_SET   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STREAM,
        ST_SETTLE,
        ST_DRAIN
    } t_state;

    // sort key: position, then track order, then slot
    typedef struct packed {
        logic [POSITION_BITS-1:0] pos;
        logic [TRACK_BITS-1:0]    trk;
        logic [TAB_AW-1:0]        idx;
    } t_key;

    typedef struct packed {
        logic clr;
        logic shift;
    } t_cell_ctl;

endpackage

// File: src/pwes_cell.sv
// ----------------------------------------------------------------------------
// pwes_cell
// One cell of the insertion sort chain: keeps the smaller key, forwards the
// larger one to the right, and shifts left while the chain drains.
// ----------------------------------------------------------------------------
module pwes_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pwes_pkg::t_cell_ctl i_ctl,
    input  logic              i_lt_valid,
    input  pwes_pkg::t_key    i_lt_key,
    input  logic              i_rt_valid,
    input  pwes_pkg::t_key    i_rt_key,
    output logic              o_fwd_valid,
    output pwes_pkg::t_key    o_fwd_key,
    output logic              o_held_valid,
    output pwes_pkg::t_key    o_held_key
);

    logic           r_held_v;
    pwes_pkg::t_key r_held_key;
    logic           r_fwd_v;
    pwes_pkg::t_key r_fwd_key;
    logic           w_lt_smaller;

    assign w_lt_smaller = i_lt_key < r_held_key;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_v <= 1'b0;
            r_fwd_v  <= 1'b0;
        end else if (i_ctl.clr) begin
            r_held_v <= 1'b0;
            r_fwd_v  <= 1'b0;
        end else if (i_ctl.shift) begin
            r_held_v   <= i_rt_valid;
            r_held_key <= i_rt_key;
            r_fwd_v    <= 1'b0;
        end else if (i_lt_valid) begin
            if (!r_held_v) begin
                r_held_v   <= 1'b1;
                r_held_key <= i_lt_key;
                r_fwd_v    <= 1'b0;
            end else if (w_lt_smaller) begin
                r_held_key <= i_lt_key;
                r_fwd_key  <= r_held_key;
                r_fwd_v    <= 1'b1;
            end else begin
                r_fwd_key <= i_lt_key;
                r_fwd_v   <= 1'b1;
            end
        end else begin
            r_fwd_v <= 1'b0;
        end
    end

    assign o_fwd_valid  = r_fwd_v;
    assign o_fwd_key    = r_fwd_key;
    assign o_held_valid = r_held_v;
    assign o_held_key   = r_held_key;

endmodule

// File: src/position_window_event_sorter_top.sv
// Poll with crossings: the table is streamed through the window test and the
// feed register into the sort chain, the chain settles, then drains through
// the output register, stalling while it is full and not taken; o_in_ready is low until idle.
// Load, clear, set and non-emitting polls leave the block idle and ready.
// Reset is synchronous, active low: all markers unnamed, position unknown,
// chain and output register empty.
// ----------------------------------------------------------------------------
// position_window_event_sorter_top
// Marker table, transport tracker and sort chain control; emits crossed
// markers in position, track order, slot order.
// ----------------------------------------------------------------------------
module position_window_event_sorter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_kind,
    input  logic [3:0]  i_entry_index,
    input  logic [47:0] i_entry_position,
    input  logic [7:0]  i_entry_track_order,
    input  logic        i_entry_named,
    input  logic [47:0] i_transport_position,
    input  logic        i_rolling,
    input  logic        i_jump,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_crossed_index,
    output logic [47:0] o_crossed_position,
    output logic [7:0]  o_crossed_track_order,
    output logic        o_last_of_run
);

    localparam int N = pwes_pkg::TABLE_ENTRIES;

    pwes_pkg::t_state r_state, n_state;
    logic [pwes_pkg::CNT_W-1:0] r_cnt;

    logic [pwes_pkg::POSITION_BITS-1:0] r_tab_pos [N];
    logic [pwes_pkg::TRACK_BITS-1:0]    r_tab_trk [N];
    logic [N-1:0]                       r_tab_named;

    logic [pwes_pkg::POSITION_BITS-1:0] r_prev;
    logic                               r_known;
    logic [pwes_pkg::POSITION_BITS-1:0] r_lo;
    logic [pwes_pkg::POSITION_BITS-1:0] r_hi;

    logic           r_feed_v, n_feed_v;
    pwes_pkg::t_key r_feed_key, n_feed_key;

    logic           r_out_v;
    pwes_pkg::t_key r_out_key;
    logic           r_out_last;

    logic               w_accept;
    logic               w_emit;
    logic               w_shift;
    logic               w_stream;
    pwes_pkg::t_cell_ctl w_ctl;
    pwes_pkg::t_kind    w_kind;
    logic [pwes_pkg::TAB_AW-1:0] w_rd;

    logic [N:0]     w_held_v;
    pwes_pkg::t_key w_held_key [N+1];
    logic [N:0]     w_fwd_v;
    pwes_pkg::t_key w_fwd_key [N+1];

    assign w_kind   = pwes_pkg::t_kind'(i_kind);
    assign w_accept = i_in_valid && o_in_ready;
    assign w_emit   = (w_kind == pwes_pkg::KIND_POLL) && i_rolling && !i_jump && r_known
                      && (i_transport_position > r_prev);
    assign w_rd     = r_cnt[pwes_pkg::TAB_AW-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pwes_pkg::ST_IDLE: begin
                if (w_accept && w_emit) n_state = pwes_pkg::ST_STREAM;
            end
            pwes_pkg::ST_STREAM: begin
                if (r_cnt == pwes_pkg::CNT_W'(N - 1)) n_state = pwes_pkg::ST_SETTLE;
            end
            pwes_pkg::ST_SETTLE: begin
                if (r_cnt == pwes_pkg::CNT_W'(N + 1)) n_state = pwes_pkg::ST_DRAIN;
            end
            pwes_pkg::ST_DRAIN: begin
                if (!w_held_v[0]) n_state = pwes_pkg::ST_IDLE;
            end
            default: n_state = pwes_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_ready = 1'b0;
        w_stream   = 1'b0;
        w_shift    = 1'b0;
        w_ctl      = '0;
        case (r_state)
            pwes_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                w_ctl.clr  = 1'b1;
            end
            pwes_pkg::ST_STREAM: w_stream = 1'b1;
            pwes_pkg::ST_SETTLE: w_stream = 1'b0;
            pwes_pkg::ST_DRAIN: begin
                w_shift     = w_held_v[0] && (!r_out_v || i_out_ready);
                w_ctl.shift = w_shift;
            end
            default: o_in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pwes_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (n_state != r_state) r_cnt <= '0;
            else                    r_cnt <= r_cnt + 1'b1;
        end
    end

    // marker table and tracker
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tab_named <= '0;
            r_known     <= 1'b0;
            r_prev      <= '0;
        end else if (w_accept) begin
            case (w_kind)
                pwes_pkg::KIND_LOAD: begin
                    if (32'(i_entry_index) < N) begin
                        r_tab_named[pwes_pkg::TAB_AW'(i_entry_index)] <= i_entry_named;
                    end
                end
                pwes_pkg::KIND_CLEAR: begin
                    r_known <= 1'b0;
                    r_prev  <= '0;
                end
                default: begin
                    r_known <= 1'b1;
                    r_prev  <= i_transport_position;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && (w_kind == pwes_pkg::KIND_LOAD) && (32'(i_entry_index) < N)) begin
            r_tab_pos[pwes_pkg::TAB_AW'(i_entry_index)] <= i_entry_position;
            r_tab_trk[pwes_pkg::TAB_AW'(i_entry_index)] <= i_entry_track_order;
        end
        if (w_accept && w_emit) begin
            r_lo <= r_prev;
            r_hi <= i_transport_position;
        end
    end

    // window test on the streamed entry, registered into the chain
    always_comb begin
        n_feed_key.pos = r_tab_pos[w_rd];
        n_feed_key.trk = r_tab_trk[w_rd];
        n_feed_key.idx = w_rd;
        n_feed_v = w_stream && r_tab_named[w_rd] && (r_tab_pos[w_rd] > r_lo)
                   && (r_tab_pos[w_rd] <= r_hi);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_feed_v <= 1'b0;
        else          r_feed_v <= n_feed_v;
        r_feed_key <= n_feed_key;
    end

    // sort chain
    assign w_fwd_v[0]        = r_feed_v;
    assign w_fwd_key[0]      = r_feed_key;
    assign w_held_v[N]       = 1'b0;
    assign w_held_key[N]     = '0;

    for (genvar g = 0; g < N; g++) begin : g_cell
        pwes_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_lt_valid   (w_fwd_v[g]),
            .i_lt_key     (w_fwd_key[g]),
            .i_rt_valid   (w_held_v[g+1]),
            .i_rt_key     (w_held_key[g+1]),
            .o_fwd_valid  (w_fwd_v[g+1]),
            .o_fwd_key    (w_fwd_key[g+1]),
            .o_held_valid (w_held_v[g]),
            .o_held_key   (w_held_key[g])
        );
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_shift) begin
            r_out_v <= 1'b1;
        end else if (i_out_ready) begin
            r_out_v <= 1'b0;
        end
        if (w_shift) begin
            r_out_key  <= w_held_key[0];
            r_out_last <= !w_held_v[1];
        end
    end

    assign o_out_valid           = r_out_v;
    assign o_crossed_index       = pwes_pkg::PORT_IDX_W'(r_out_key.idx);
    assign o_crossed_position    = r_out_key.pos;
    assign o_crossed_track_order = r_out_key.trk;
    assign o_last_of_run         = r_out_last;

`ifndef SYNTH
    a_idle_chain_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pwes_pkg::ST_IDLE) |-> (w_held_v == '0))
        else $error("sort chain not empty while idle");

    a_drain_settled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pwes_pkg::ST_DRAIN) |-> (w_fwd_v == '0))
        else $error("key still in flight during drain");

    a_chain_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pwes_pkg::ST_DRAIN) |-> $onehot0(w_held_v[N-1:0] + 1'b1))
        else $error("occupied cells not contiguous");
`endif

endmodule

// File: dv/tb_position_window_event_sorter_top.sv
// ----------------------------------------------------------------------------
// tb_position_window_event_sorter_top
// Self-checking bench for the marker window sorter. Loads marker tables, moves
// the transport through them and checks every crossing, in sort order, against
// a local model of the table and the transport tracker. Both handshakes idle at
// random.
// ----------------------------------------------------------------------------
module tb_position_window_event_sorter_top;

    localparam logic [47:0] POS_MAX = '1;

    typedef struct {
        pwes_pkg::t_kind kind;
        logic [3:0]  idx;
        logic [47:0] epos;
        logic [7:0]  etrk;
        logic        named;
        logic [47:0] tpos;
        logic        rolling;
        logic        jump;
        bit          hold;
    } t_sorter_item;

    typedef struct {
        logic [3:0]  idx;
        logic [47:0] pos;
        logic [7:0]  trk;
        logic        last;
    } t_crossing;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_kind = '0;
    logic [3:0]  i_entry_index = '0;
    logic [47:0] i_entry_position = '0;
    logic [7:0]  i_entry_track_order = '0;
    logic        i_entry_named = 1'b0;
    logic [47:0] i_transport_position = '0;
    logic        i_rolling = 1'b0;
    logic        i_jump = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [3:0]  o_crossed_index;
    logic [47:0] o_crossed_position;
    logic [7:0]  o_crossed_track_order;
    logic        o_last_of_run;

    position_window_event_sorter_top dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_in_valid            (i_in_valid),
        .o_in_ready            (o_in_ready),
        .i_kind                (i_kind),
        .i_entry_index         (i_entry_index),
        .i_entry_position      (i_entry_position),
        .i_entry_track_order   (i_entry_track_order),
        .i_entry_named         (i_entry_named),
        .i_transport_position  (i_transport_position),
        .i_rolling             (i_rolling),
        .i_jump                (i_jump),
        .o_out_valid           (o_out_valid),
        .i_out_ready           (i_out_ready),
        .o_crossed_index       (o_crossed_index),
        .o_crossed_position    (o_crossed_position),
        .o_crossed_track_order (o_crossed_track_order),
        .o_last_of_run         (o_last_of_run)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // model of the marker table and transport tracker
    logic [47:0]  mark_pos [16];
    logic [7:0]   mark_trk [16];
    logic         mark_named [16];
    logic [47:0]  last_pos;
    logic         pos_known;

    t_sorter_item pending_q[$];
    t_crossing    crossing_q[$];
    t_sorter_item drv_item;
    t_sorter_item seen_item;
    t_crossing    got;
    t_crossing    want;
    bit           next_hold;
    bit           in_taken;
    int           gen_count;
    int           sent_count;
    int           errors;
    int           checked;
    int           kind_seen [4];
    int           emit_polls;
    int           longest_run;

    function automatic void track_window(input t_sorter_item it);
        bit          pick [16];
        logic [59:0] best_key;
        logic [59:0] key;
        int          best;
        int          n;
        t_crossing   c;
        case (it.kind)
            pwes_pkg::KIND_LOAD: begin
                mark_pos[it.idx]   = it.epos;
                mark_trk[it.idx]   = it.etrk;
                mark_named[it.idx] = it.named;
            end
            pwes_pkg::KIND_CLEAR: begin
                pos_known = 1'b0;
                last_pos  = '0;
            end
            default: begin
                if (it.kind == pwes_pkg::KIND_SET || !it.rolling || it.jump || !pos_known ||
                    it.tpos <= last_pos) begin
                    pos_known = 1'b1;
                    last_pos  = it.tpos;
                end else begin
                    for (int i = 0; i < 16; i++)
                        pick[i] = mark_named[i] && mark_pos[i] > last_pos &&
                                  mark_pos[i] <= it.tpos;
                    for (n = 0; n < 16; n++) begin
                        best = -1;
                        best_key = '0;
                        for (int i = 0; i < 16; i++) begin
                            key = {mark_pos[i], mark_trk[i], i[3:0]};
                            if (pick[i] && (best < 0 || key < best_key)) begin
                                best = i;
                                best_key = key;
                            end
                        end
                        if (best < 0)
                            break;
                        pick[best] = 1'b0;
                        c.idx  = best[3:0];
                        c.pos  = mark_pos[best];
                        c.trk  = mark_trk[best];
                        c.last = 1'b0;
                        crossing_q = {crossing_q, c};
                    end
                    if (n > 0) begin
                        crossing_q[crossing_q.size() - 1].last = 1'b1;
                        emit_polls++;
                        if (n > longest_run)
                            longest_run = n;
                    end
                    last_pos = it.tpos;
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------ stimulus
    function automatic logic [47:0] rand48();
        logic [47:0] r;
        r[47:32] = 16'($urandom);
        r[31:0]  = $urandom;
        return r;
    endfunction

    function automatic logic [47:0] pick_base();
        case ($urandom_range(3))
            0:       return '0;
            1:       return rand48();
            2:       return POS_MAX - 48'($urandom_range(20000));
            default: return rand48() & 48'hFFFF;
        endcase
    endfunction

    function automatic t_sorter_item noise_item();
        t_sorter_item it;
        it.kind    = pwes_pkg::t_kind'($urandom_range(3));
        it.idx     = 4'($urandom);
        it.epos    = rand48();
        it.etrk    = 8'($urandom);
        it.named   = 1'($urandom);
        it.tpos    = rand48();
        it.rolling = 1'($urandom);
        it.jump    = 1'($urandom);
        it.hold    = 1'b0;
        return it;
    endfunction

    function automatic void queue_item(input t_sorter_item it);
        it.hold = next_hold;
        next_hold = 1'b0;
        pending_q = {pending_q, it};
        gen_count++;
    endfunction

    function automatic void add_load(input logic [3:0] idx, input logic [47:0] pos,
                                     input logic [7:0] trk, input logic named);
        t_sorter_item it;
        it = noise_item();
        it.kind  = pwes_pkg::KIND_LOAD;
        it.idx   = idx;
        it.epos  = pos;
        it.etrk  = trk;
        it.named = named;
        queue_item(it);
    endfunction

    function automatic void add_poll(input logic [47:0] pos, input logic rolling,
                                     input logic jump);
        t_sorter_item it;
        it = noise_item();
        it.kind    = pwes_pkg::KIND_POLL;
        it.tpos    = pos;
        it.rolling = rolling;
        it.jump    = jump;
        queue_item(it);
    endfunction

    function automatic void add_set(input logic [47:0] pos);
        t_sorter_item it;
        it = noise_item();
        it.kind = pwes_pkg::KIND_SET;
        it.tpos = pos;
        queue_item(it);
    endfunction

    function automatic void add_clear();
        t_sorter_item it;
        it = noise_item();
        it.kind = pwes_pkg::KIND_CLEAR;
        queue_item(it);
    endfunction

    function automatic void build_stimulus();
        logic [47:0] base;
        logic [47:0] cur;
        int          roll;
        // directed: ties on position and track, unnamed slot, position extremes
        add_poll(48'd500, 1'b1, 1'b0);
        add_load(4'd0, POS_MAX, 8'd255, 1'b1);
        add_load(4'd15, 48'd1, 8'd0, 1'b1);
        add_load(4'd7, 48'd1, 8'd0, 1'b1);
        add_load(4'd3, 48'd1, 8'd0, 1'b0);
        add_load(4'd8, 48'd2, 8'd5, 1'b1);
        add_load(4'd9, 48'd2, 8'd3, 1'b1);
        add_set('0);
        add_poll(48'd2, 1'b1, 1'b0);
        add_poll(48'd2, 1'b1, 1'b0);
        add_poll(48'd1, 1'b1, 1'b0);
        add_poll(48'd100, 1'b0, 1'b0);
        add_poll(48'd200, 1'b1, 1'b1);
        add_clear();
        add_poll(POS_MAX, 1'b1, 1'b0);
        next_hold = 1'b1;
        add_set(POS_MAX - 48'd1);
        add_poll(POS_MAX, 1'b1, 1'b0);
        add_set('0);
        add_poll(POS_MAX, 1'b1, 1'b0);
        add_load(4'd0, '0, 8'd0, 1'b1);
        add_set('0);
        add_poll(48'd10, 1'b1, 1'b0);
        next_hold = 1'b1;
        while (gen_count < 380) begin
            roll = $urandom_range(99);
            if ($urandom_range(7) == 0)
                next_hold = 1'b1;
            base = pick_base();
            cur  = base;
            if (roll < 62) begin
                repeat ($urandom_range(1, 8)) begin
                    if ($urandom_range(1))
                        add_load(4'($urandom), base + 48'(200 * $urandom_range(1, 15)),
                                 8'($urandom_range(3)), $urandom_range(9) < 8);
                    else
                        add_load(4'($urandom), base + 48'($urandom_range(1, 3000)),
                                 8'($urandom), $urandom_range(9) < 8);
                end
                if ($urandom_range(1))
                    add_set(base);
                else
                    add_poll(base, 1'b0, 1'($urandom));
                repeat ($urandom_range(2, 6)) begin
                    cur = cur + 48'($urandom_range(1200));
                    add_poll(cur, 1'b1, 1'b0);
                end
            end else if (roll < 77) begin
                for (int i = 0; i < 16; i++)
                    add_load(4'(i), base + 48'(50 * $urandom_range(1, 40)),
                             8'($urandom_range(2)), 1'b1);
                add_set(base);
                add_poll(base + 48'd5000, 1'b1, 1'b0);
            end else if (roll < 90) begin
                add_set(base);
                repeat (3) begin
                    case ($urandom_range(3))
                        0: add_poll(cur + 48'($urandom_range(2000)), 1'b1, 1'b1);
                        1: add_poll(cur + 48'($urandom_range(2000)), 1'b0, 1'b0);
                        2: add_poll(cur - 48'($urandom_range(2000)), 1'b1, 1'b0);
                        default: add_clear();
                    endcase
                    cur = cur + 48'($urandom_range(1500));
                    add_poll(cur, 1'b1, 1'b0);
                end
            end else begin
                repeat ($urandom_range(1, 4))
                    queue_item(noise_item());
            end
        end
    endfunction

    // ------------------------------------------------------------------ driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!(i_in_valid && !in_taken)) begin
                if (pending_q.size() > 0 &&
                    ((sent_count >= 170 && sent_count < 250) ||
                     $urandom_range(99) >= 28) &&
                    (!pending_q[0].hold || crossing_q.size() == 0)) begin
                    drv_item = pending_q.pop_front();
                    i_kind               <= drv_item.kind;
                    i_entry_index        <= drv_item.idx;
                    i_entry_position     <= drv_item.epos;
                    i_entry_track_order  <= drv_item.etrk;
                    i_entry_named        <= drv_item.named;
                    i_transport_position <= drv_item.tpos;
                    i_rolling            <= drv_item.rolling;
                    i_jump               <= drv_item.jump;
                    i_in_valid           <= 1'b1;
                    sent_count++;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_ready <= (sent_count >= 170 && sent_count < 250) ||
                           $urandom_range(99) >= 28;
        end
    end

    // ------------------------------------------------------------------ monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                got.idx  = o_crossed_index;
                got.pos  = o_crossed_position;
                got.trk  = o_crossed_track_order;
                got.last = o_last_of_run;
                if (crossing_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected crossing idx %0d pos %0d trk %0d last %0d",
                             $time, got.idx, got.pos, got.trk, got.last);
                end else begin
                    want = crossing_q.pop_front();
                    checked++;
                    if (got.idx !== want.idx || got.pos !== want.pos ||
                        got.trk !== want.trk || got.last !== want.last) begin
                        errors++;
                        $display("%0t: mismatch expected idx %0d pos %0d trk %0d last %0d",
                                 $time, want.idx, want.pos, want.trk, want.last);
                        $display("%0t:          actual   idx %0d pos %0d trk %0d last %0d",
                                 $time, got.idx, got.pos, got.trk, got.last);
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                seen_item.kind    = pwes_pkg::t_kind'(i_kind);
                seen_item.idx     = i_entry_index;
                seen_item.epos    = i_entry_position;
                seen_item.etrk    = i_entry_track_order;
                seen_item.named   = i_entry_named;
                seen_item.tpos    = i_transport_position;
                seen_item.rolling = i_rolling;
                seen_item.jump    = i_jump;
                seen_item.hold    = 1'b0;
                kind_seen[i_kind]++;
                track_window(seen_item);
            end
        end
        in_taken <= i_rst_n && i_in_valid && o_in_ready;
    end

    // ------------------------------------------------------------------ sequence
    initial begin
        for (int i = 0; i < 16; i++) begin
            mark_pos[i]   = '0;
            mark_trk[i]   = '0;
            mark_named[i] = 1'b0;
        end
        for (int i = 0; i < 4; i++)
            kind_seen[i] = 0;
        last_pos    = '0;
        pos_known   = 1'b0;
        next_hold   = 1'b0;
        in_taken    = 1'b0;
        gen_count   = 0;
        sent_count  = 0;
        errors      = 0;
        checked     = 0;
        emit_polls  = 0;
        longest_run = 0;
        build_stimulus();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_q.size() > 0 || i_in_valid)
            @(posedge i_clk);
        while (crossing_q.size() > 0)
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        if (crossing_q.size() > 0) begin
            errors++;
            $display("%0t: %0d crossings never arrived", $time, crossing_q.size());
        end
        $display("run: %0d loads, %0d polls, %0d clears, %0d position sets accepted",
                 kind_seen[pwes_pkg::KIND_LOAD], kind_seen[pwes_pkg::KIND_POLL],
                 kind_seen[pwes_pkg::KIND_CLEAR], kind_seen[pwes_pkg::KIND_SET]);
        $display("run: %0d crossings checked from %0d emitting polls, longest run %0d",
                 checked, emit_polls, longest_run);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
